/* design/spi_register_access_master_defines.svh */
// ----------------------------------------------------------------------------
// SPI register access master: assertion macros
// Shared same-cycle-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef SPI_REGISTER_ACCESS_MASTER_DEFINES_SVH
`define SPI_REGISTER_ACCESS_MASTER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SPIRAM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("spiram check failed");

// next-cycle implication, disabled while reset is low
`define SPIRAM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("spiram check failed");

`endif

/* design/spiram_pkg.sv */
// ----------------------------------------------------------------------------
// SPI register access master package
// Command codes, decoded item type and queue sizing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spiram_pkg;

    localparam int CMD_W    = 2;
    localparam int ADDR_W   = 7;
    localparam int WORD_W   = 16;
    localparam int CFG_W    = 8;
    localparam int BITS_W   = 5;
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = 1;
    localparam int Q_CNT_W  = 2;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DATA  = 2'd2;

    // top bit of the address byte marks a write
    localparam logic [7:0] ADDR_WRITE_FLAG = 8'h80;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_BEGIN,
        OP_DATA,
        OP_BAD
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] reg_addr;
        logic              is_read;
        logic [WORD_W-1:0] wdata;
        logic              wide;
        logic              last_word;
        logic              miso;
    } t_item;

    function automatic t_op decode_cmd(input logic [CMD_W-1:0] cmd);
        t_op op;
        case (cmd)
            CMD_TICK:  op = OP_TICK;
            CMD_BEGIN: op = OP_BEGIN;
            CMD_DATA:  op = OP_DATA;
            default:   op = OP_BAD;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

/* design/spiram_in_if.sv */
// ----------------------------------------------------------------------------
// SPI register access master command channel
// Valid/ready channel carrying one command item per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface spiram_in_if;
    import spiram_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] reg_addr;
    logic              is_read;
    logic [WORD_W-1:0] wdata;
    logic              wide;
    logic              last_word;
    logic              miso;

    modport source (
        output valid, cmd, reg_addr, is_read, wdata, wide, last_word, miso,
        input  ready
    );

    modport sink (
        input  valid, cmd, reg_addr, is_read, wdata, wide, last_word, miso,
        output ready
    );
endinterface

`default_nettype wire

/* design/spiram_out_if.sv */
// ----------------------------------------------------------------------------
// SPI register access master result channel
// Valid/ready channel carrying pin levels and status per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface spiram_out_if;
    import spiram_pkg::*;

    logic              valid;
    logic              ready;
    logic              csn;
    logic              sclk;
    logic              mosi;
    logic              busy_res;
    logic              rdata_valid;
    logic [WORD_W-1:0] rdata;
    logic              cmd_error;

    modport source (
        output valid, csn, sclk, mosi, busy_res, rdata_valid, rdata, cmd_error,
        input  ready
    );

    modport sink (
        input  valid, csn, sclk, mosi, busy_res, rdata_valid, rdata, cmd_error,
        output ready
    );
endinterface

`default_nettype wire

/* design/spiram_front.sv */
// ----------------------------------------------------------------------------
// SPI register access master front end
// Accepts command transfers, decodes them and holds them in a short queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spiram_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    spiram_in_if.sink           i_in,
    output spiram_pkg::t_item   o_item,
    output logic                o_item_valid,
    input  wire                 i_item_pop
);
    import spiram_pkg::*;

    t_item                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count,  n_count;
    logic                 push;
    logic                 pop;
    t_item                dec_item;

    assign i_in.ready   = (r_count != Q_CNT_W'(Q_DEPTH));
    assign push         = i_in.valid && i_in.ready;
    assign o_item_valid = (r_count != '0);
    assign pop          = i_item_pop && o_item_valid;
    assign o_item       = r_mem[r_rd_ptr];

    always_comb begin
        dec_item.op        = decode_cmd(i_in.cmd);
        dec_item.reg_addr  = i_in.reg_addr;
        dec_item.is_read   = i_in.is_read;
        dec_item.wdata     = i_in.wdata;
        dec_item.wide      = i_in.wide;
        dec_item.last_word = i_in.last_word;
        dec_item.miso      = i_in.miso;
    end

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + Q_PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + Q_PTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + Q_CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= dec_item;
        end
    end

endmodule

`default_nettype wire

/* design/spiram_back.sv */
// ----------------------------------------------------------------------------
// SPI register access master back end
// Runs the serial line sequencer on queued items and registers each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "spi_register_access_master_defines.svh"

module spiram_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire spiram_pkg::t_item       i_item,
    input  wire                          i_item_valid,
    output logic                         o_item_pop,
    input  wire                          i_cfg_we,
    input  wire [spiram_pkg::CFG_W-1:0]  i_cfg_wdata,
    spiram_out_if.source                 o_out
);
    import spiram_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT,
        PH_AHIGH,
        PH_ALOW,
        PH_WHIGH,
        PH_WLOW,
        PH_RHIGH,
        PH_RLOW
    } t_phase;

    t_phase              r_phase,        n_phase;
    logic [WORD_W-1:0]   r_shift,        n_shift;
    logic [BITS_W-1:0]   r_bits_left,    n_bits_left;
    logic [CFG_W-1:0]    r_high_count,   n_high_count;
    logic                r_read_mode,    n_read_mode;
    logic                r_word_wide,    n_word_wide;
    logic                r_end_after,    n_end_after;
    logic                r_chip_select,  n_chip_select;
    logic                r_mosi,         n_mosi;
    logic [CFG_W-1:0]    r_read_high_ticks;

    logic                r_out_valid;
    logic                r_out_csn;
    logic                r_out_sclk;
    logic                r_out_mosi;
    logic                r_out_busy;
    logic                r_out_rvalid;
    logic [WORD_W-1:0]   r_out_rdata;
    logic                r_out_err;

    logic                pop;
    logic                res_rvalid;
    logic [WORD_W-1:0]   res_rdata;
    logic                res_err;
    logic [CFG_W-1:0]    limit;
    logic [BITS_W-1:0]   bits_dec;
    logic [WORD_W-1:0]   shift_in;
    logic [7:0]          addr_byte;

    function automatic logic clock_level(input t_phase ph, input logic [CFG_W-1:0] hc);
        logic lvl;
        case (ph)
            PH_ALOW, PH_WLOW, PH_RLOW: lvl = 1'b1;
            PH_RHIGH:                  lvl = (hc != '0);
            default:                   lvl = 1'b0;
        endcase
        return lvl;
    endfunction

    assign pop        = i_item_valid && (!r_out_valid || o_out.ready);
    assign o_item_pop = pop;

    // zero high time behaves as one
    assign limit     = (r_read_high_ticks == '0) ? CFG_W'(1) : r_read_high_ticks;
    assign bits_dec  = (r_bits_left != '0) ? r_bits_left - BITS_W'(1) : r_bits_left;
    assign shift_in  = {r_shift[WORD_W-2:0], i_item.miso};
    assign addr_byte = i_item.is_read ? {1'b0, i_item.reg_addr}
                                      : ({1'b0, i_item.reg_addr} | ADDR_WRITE_FLAG);

    always_comb begin
        n_phase       = r_phase;
        n_shift       = r_shift;
        n_bits_left   = r_bits_left;
        n_high_count  = r_high_count;
        n_read_mode   = r_read_mode;
        n_word_wide   = r_word_wide;
        n_end_after   = r_end_after;
        n_chip_select = r_chip_select;
        n_mosi        = r_mosi;
        res_rvalid    = 1'b0;
        res_rdata     = '0;
        res_err       = 1'b0;

        if (pop) begin
            case (i_item.op)
                OP_TICK: begin
                    case (r_phase)
                        PH_WAIT: begin
                            if (r_end_after) begin
                                n_chip_select = 1'b1;
                                n_end_after   = 1'b0;
                                n_phase       = PH_IDLE;
                            end
                        end
                        PH_AHIGH, PH_WHIGH: begin
                            n_mosi  = r_shift[WORD_W-1];
                            n_shift = {r_shift[WORD_W-2:0], 1'b0};
                            n_phase = (r_phase == PH_AHIGH) ? PH_ALOW : PH_WLOW;
                        end
                        PH_ALOW, PH_WLOW: begin
                            n_bits_left = bits_dec;
                            if (bits_dec != '0) begin
                                n_phase = (r_phase == PH_ALOW) ? PH_AHIGH : PH_WHIGH;
                            end else begin
                                n_phase = PH_WAIT;
                            end
                        end
                        PH_RHIGH: begin
                            // saturating high-time counter
                            if (r_high_count != '1) begin
                                n_high_count = r_high_count + CFG_W'(1);
                            end
                            if (n_high_count >= limit) begin
                                n_phase = PH_RLOW;
                            end
                        end
                        PH_RLOW: begin
                            n_shift      = shift_in;
                            n_high_count = '0;
                            n_bits_left  = bits_dec;
                            if (bits_dec != '0) begin
                                n_phase = PH_RHIGH;
                            end else begin
                                res_rvalid = 1'b1;
                                res_rdata  = r_word_wide ? shift_in : {8'h00, shift_in[7:0]};
                                n_phase    = PH_WAIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                OP_BEGIN: begin
                    if (r_phase != PH_IDLE) begin
                        res_err = 1'b1;
                    end else begin
                        n_read_mode   = i_item.is_read;
                        n_chip_select = 1'b0;
                        n_end_after   = 1'b0;
                        n_shift       = {addr_byte, 8'h00};
                        n_bits_left   = BITS_W'(8);
                        n_high_count  = '0;
                        n_phase       = PH_AHIGH;
                    end
                end
                OP_DATA: begin
                    if (r_phase != PH_WAIT || r_end_after) begin
                        res_err = 1'b1;
                    end else begin
                        n_word_wide  = i_item.wide;
                        n_end_after  = i_item.last_word;
                        n_bits_left  = i_item.wide ? BITS_W'(16) : BITS_W'(8);
                        n_high_count = '0;
                        if (r_read_mode) begin
                            n_shift = '0;
                            n_phase = PH_RHIGH;
                        end else begin
                            n_shift = i_item.wide ? i_item.wdata
                                                  : {i_item.wdata[7:0], 8'h00};
                            n_phase = PH_WHIGH;
                        end
                    end
                end
                default: begin
                    res_err = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_IDLE;
            r_shift           <= '0;
            r_bits_left       <= '0;
            r_high_count      <= '0;
            r_read_mode       <= 1'b0;
            r_word_wide       <= 1'b0;
            r_end_after       <= 1'b0;
            r_chip_select     <= 1'b1;
            r_mosi            <= 1'b0;
            r_read_high_ticks <= CFG_W'(1);
            r_out_valid       <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_shift       <= n_shift;
            r_bits_left   <= n_bits_left;
            r_high_count  <= n_high_count;
            r_read_mode   <= n_read_mode;
            r_word_wide   <= n_word_wide;
            r_end_after   <= n_end_after;
            r_chip_select <= n_chip_select;
            r_mosi        <= n_mosi;
            if (i_cfg_we) begin
                r_read_high_ticks <= i_cfg_wdata;
            end
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_csn    <= n_chip_select;
            r_out_sclk   <= clock_level(n_phase, n_high_count);
            r_out_mosi   <= n_mosi;
            r_out_busy   <= (n_bits_left != '0);
            r_out_rvalid <= res_rvalid;
            r_out_rdata  <= res_rdata;
            r_out_err    <= res_err;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.csn         = r_out_csn;
    assign o_out.sclk        = r_out_sclk;
    assign o_out.mosi        = r_out_mosi;
    assign o_out.busy_res    = r_out_busy;
    assign o_out.rdata_valid = r_out_rvalid;
    assign o_out.rdata       = r_out_rdata;
    assign o_out.cmd_error   = r_out_err;

    // a completed read word only comes out of a read transaction
    `SPIRAM_ASSERT_NEXT(a_rvalid_in_read, i_clk, i_rst_n, pop && res_rvalid, r_read_mode)
    // idle means deselected and nothing left to shift
    `SPIRAM_ASSERT_NOW(a_idle_clean, i_clk, i_rst_n, r_phase == PH_IDLE,
        r_chip_select && (r_bits_left == '0))
    // a word never has more than sixteen bits
    `SPIRAM_ASSERT_NOW(a_bits_range, i_clk, i_rst_n, 1'b1, r_bits_left <= BITS_W'(16))
    // an out-of-order item leaves the sequencer untouched
    `SPIRAM_ASSERT_NEXT(a_err_holds, i_clk, i_rst_n, pop && res_err,
        (r_phase == $past(r_phase)) && (r_bits_left == $past(r_bits_left)))

endmodule

`default_nettype wire

/* design/spi_register_access_master.sv */
// Path: a command passes the decode queue stage and the sequencer result register,
// then reaches the result channel. Throughput: one command per cycle while the
// result side is ready; the 2-entry decode queue absorbs result stalls.
// Reset (synchronous, active low): sequencer chip select high and data low,
// sequencer idle, queue empty, read high time back to 1; pin registers not reset.
`timescale 1ns / 1ps
`default_nettype none

// ----------------------------------------------------------------------------
// SPI register access master
// Decode front end and serial line sequencer joined by a short item queue.
// ----------------------------------------------------------------------------
module spi_register_access_master (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    spiram_in_if.sink                    i_in,
    spiram_out_if.source                 o_out,
    input  wire                          i_cfg_we,
    input  wire [spiram_pkg::CFG_W-1:0]  i_cfg_wdata
);
    import spiram_pkg::*;

    t_item item;
    logic  item_valid;
    logic  item_pop;

    spiram_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_item       (item),
        .o_item_valid (item_valid),
        .i_item_pop   (item_pop)
    );

    spiram_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_item_pop   (item_pop),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire
